### src/atanh_power_series_assert.svh
// Assertion macros for the artanh series block.
// Expects clk and arst_n in the scope of each use.
`ifndef ATANH_POWER_SERIES_ASSERT_SVH
`define ATANH_POWER_SERIES_ASSERT_SVH

// same-cycle implication
`define ATANH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ATANH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/atanh_pkg.sv
// Shared widths, constants and types of the artanh series block.
// No dependencies.
`default_nettype none

package atanh_pkg;

	localparam int X_W      = 17;
	localparam int THR_W    = 16;
	localparam int SUM_W    = 19;
	localparam int CNT_W    = 7;
	localparam int PW       = 41;
	localparam int PROD_W   = PW + X_W;

	localparam logic [PW-1:0]    POW_CAP   = PW'(1) << (PW - 1);
	localparam logic [SUM_W-1:0] SUM_MAX   = SUM_W'(262143);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

	localparam int MAX_TERMS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_TERM,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### src/atanh_if.sv
// Handshake channels of the artanh series block: argument in, result out.
// Depends on atanh_pkg.
`default_nettype none

interface atanh_arg_if import atanh_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [X_W-1:0]  x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface

interface atanh_res_if import atanh_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] series_sum;
	logic [CNT_W-1:0]        terms_used;
	logic                    cap_reached;

	modport source (output valid, output series_sum, output terms_used, output cap_reached,
		input ready);
	modport sink   (input valid, input series_sum, input terms_used, input cap_reached,
		output ready);
endinterface

`default_nettype wire

### src/atanh_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on atanh_pkg.
`default_nettype none

module atanh_div import atanh_pkg::*; #(
	parameter int KW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [PW-1:0] dividend,
	input  wire logic [KW-1:0] divisor,
	output logic               done,
	output logic [PW-1:0]      quotient
);

	localparam int CW = $clog2(PW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] num_q;
	logic [KW-1:0] rem_q;
	logic [KW-1:0] d_q;
	logic [KW:0]   trial;
	logic [KW:0]   diff;
	logic          ge;

	assign trial    = {rem_q, num_q[PW-1]};
	assign ge       = trial >= {1'b0, d_q};
	assign diff     = trial - {1'b0, d_q};
	assign done     = busy_q && (cnt_q == CW'(1));
	assign quotient = {num_q[PW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			num_q <= quotient;
			rem_q <= ge ? diff[KW-1:0] : trial[KW-1:0];
		end
	end

endmodule

`default_nettype wire

### src/atanh_mul.sv
// Bit-serial power update: P <- clamp(round(clamp(round(P*m))*m)).
// Two shift-add passes over the bits of m. Depends on atanh_pkg.
`default_nettype none

module atanh_mul import atanh_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [PW-1:0]  p_in,
	input  wire logic [X_W-1:0] m,
	output logic                busy,
	output logic [PW-1:0]       p_out
);

	localparam int BW = $clog2(X_W);
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic              busy_q;
	logic              rnd_q;
	logic              pass_q;
	logic [BW-1:0]     cnt_q;
	logic [X_W-1:0]    m_sh_q;
	logic [PW-1:0]     p_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] rsum;
	logic [PROD_W-1:0] rshift;
	logic [PW-1:0]     p_next;

	assign rsum   = acc_q + HALF;
	assign rshift = rsum >> FRAC_BITS;
	assign p_next = (rshift > PROD_W'(POW_CAP)) ? POW_CAP : rshift[PW-1:0];
	assign busy   = busy_q;
	assign p_out  = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			pass_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= 1'b0;
			pass_q <= 1'b0;
			cnt_q  <= BW'(X_W - 1);
		end else if (busy_q) begin
			if (!rnd_q) begin
				if (cnt_q == '0)
					rnd_q <= 1'b1;
				else
					cnt_q <= cnt_q - BW'(1);
			end else begin
				rnd_q <= 1'b0;
				if (pass_q) begin
					busy_q <= 1'b0;
				end else begin
					pass_q <= 1'b1;
					cnt_q  <= BW'(X_W - 1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q    <= p_in;
			m_sh_q <= m;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (!rnd_q) begin
				acc_q  <= (acc_q << 1) + (m_sh_q[X_W-1] ? PROD_W'(p_q) : '0);
				m_sh_q <= {m_sh_q[X_W-2:0], m_sh_q[X_W-1]};
			end else begin
				p_q   <= p_next;
				acc_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### src/atanh_power_series.sv
// artanh(x) by the odd power series x + x^3/3 + x^5/5 + ..., in fixed point.
// One argument at a time. Each term passes through the test state and then the
// bit-serial divider by 2i+1; the power update for the next term runs in its shadow.
// No term is computed when |x| is at or below the threshold. A finished result
// waits in an output register while the next argument is taken. Depends on
// atanh_pkg, atanh_if, atanh_div, atanh_mul and atanh_power_series_assert.svh.
`default_nettype none

module atanh_power_series import atanh_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [THR_W-1:0] cfg_wdata,
	atanh_arg_if.sink             arg,
	atanh_res_if.source           result
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int KW = $clog2(2 * MAX_TERMS);
	localparam int SW = PW + CW;

	state_t state_q, state_d;

	logic [THR_W-1:0] thr_q;
	logic [X_W-1:0]   m_q;
	logic             neg_q;
	logic [PW-1:0]    p_q;
	logic [PW-1:0]    cur_q;
	logic [SW-1:0]    sum_q;
	logic [CW-1:0]    i_q;
	logic             out_valid_q;

	logic [X_W-1:0]   m_in;
	logic             over_thr;
	logic             go;
	logic             out_free;
	logic             out_load;
	logic             term_start;
	logic [KW-1:0]    k;
	logic [PW-1:0]    dividend;
	logic             div_done;
	logic [PW-1:0]    quot;
	logic             mul_busy;
	logic [PW-1:0]    mul_p;
	logic [SUM_W-1:0] mag;
	logic             cap;

	assign m_in     = arg.x_value[X_W-1] ? X_W'(-arg.x_value) : arg.x_value;
	assign over_thr = cur_q > PW'(thr_q);
	assign go       = over_thr && (i_q < CW'(MAX_TERMS));
	assign out_free = !out_valid_q || result.ready;
	assign k        = KW'({i_q, 1'b1});
	assign dividend = p_q + PW'(i_q);
	assign mag      = (sum_q > SW'(SUM_MAX)) ? SUM_MAX : sum_q[SUM_W-1:0];
	assign cap      = (i_q == CW'(MAX_TERMS)) && over_thr;

	atanh_div #(.KW(KW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (term_start),
		.dividend (dividend),
		.divisor  (k),
		.done     (div_done),
		.quotient (quot)
	);

	atanh_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (term_start),
		.p_in   (p_q),
		.m      (m_q),
		.busy   (mul_busy),
		.p_out  (mul_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (arg.valid) state_d = ST_TEST;
			ST_TEST: state_d = go ? ST_TERM : ST_DONE;
			ST_TERM: if (div_done) state_d = ST_TEST;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		arg.ready  = (state_q == ST_IDLE);
		term_start = (state_q == ST_TEST) && go;
		out_load   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen)
				thr_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (arg.valid && arg.ready) begin
			m_q   <= m_in;
			neg_q <= arg.x_value[X_W-1];
			p_q   <= PW'(m_in);
			cur_q <= PW'(m_in);
			sum_q <= '0;
			i_q   <= '0;
		end else if ((state_q == ST_TERM) && div_done) begin
			sum_q <= sum_q + SW'(quot);
			cur_q <= quot;
			i_q   <= i_q + CW'(1);
			p_q   <= mul_p;
		end
		if (out_load) begin
			result.series_sum  <= neg_q ? -mag : mag;
			result.terms_used  <= CNT_W'(i_q);
			result.cap_reached <= cap;
		end
	end

	assign result.valid = out_valid_q;

`include "atanh_power_series_assert.svh"

	`ATANH_ASSERT_IMP(a_mul_before_div, (state_q == ST_TERM) && div_done, !mul_busy,
		"power update still busy when the term is done")
	`ATANH_ASSERT_IMP(a_count_bound, state_q != ST_IDLE, i_q <= CW'(MAX_TERMS),
		"term count beyond the cap")
	`ATANH_ASSERT_NXT(a_count_step, (state_q == ST_TERM) && div_done,
		i_q == $past(i_q) + CW'(1), "term count did not advance by one")
	`ATANH_ASSERT_IMP(a_cap_count, out_load && cap, i_q == CW'(MAX_TERMS),
		"cap flag without a full count")

endmodule

`default_nettype wire
